@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the envelope generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define ADSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked property check that also holds during reset.
`define ADSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/adsr_pkg.sv @@
// Package: widths, register map and state types of the ADSR envelope generator.
`default_nettype none

package adsr_pkg;

  // Default field widths
  localparam int unsigned AMP_BITS_DEF = 16;
  localparam int unsigned LEN_BITS_DEF = 24;

  // APB address width: six 32-bit registers at 4-byte spacing
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_PEAK    = 3'd0;
  localparam logic [2:0] REG_SUSTAIN = 3'd1;
  localparam logic [2:0] REG_ATTACK  = 3'd2;
  localparam logic [2:0] REG_DECAY   = 3'd3;
  localparam logic [2:0] REG_RELEASE = 3'd4;
  localparam logic [2:0] REG_TOTAL   = 3'd5;

  // Top-level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEG,
    ST_CALC,
    ST_DONE
  } state_e;

  // Serial multiply/divide unit
  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_phase_e;

endpackage

`default_nettype wire

@@ hw/rtl/adsr_muldiv.sv @@
// Bit-serial unit: quot = (mplier * mcand) / divisor, shift-add then restoring divide.
`default_nettype none
`include "assert_macros.svh"

module adsr_muldiv #(
  parameter int unsigned AMP_BITS = adsr_pkg::AMP_BITS_DEF,
  parameter int unsigned LEN_BITS = adsr_pkg::LEN_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [AMP_BITS-1:0] mplier_i,
  input  logic [LEN_BITS-1:0] mcand_i,
  input  logic [LEN_BITS-1:0] divisor_i,
  output logic                done_o,
  output logic [AMP_BITS-1:0] quot_o
);

  localparam int unsigned W     = AMP_BITS + LEN_BITS;
  localparam int unsigned CNT_W = $clog2(AMP_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AMP_BITS - 1);

  adsr_pkg::md_phase_e phase_q, phase_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [AMP_BITS-1:0] mpl_q, mpl_d;
  logic [LEN_BITS-1:0] mcand_q, mcand_d;
  logic [LEN_BITS-1:0] div_q, div_d;
  logic [W-1:0]        acc_q, acc_d;

  // Divide step: remainder sits in the top LEN_BITS, quotient shifts in at the bottom
  logic [LEN_BITS:0]   trial;
  logic [LEN_BITS:0]   diff;
  logic                ge;

  assign trial = {acc_q[W-1:AMP_BITS], acc_q[AMP_BITS-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= adsr_pkg::MD_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mpl_q   <= mpl_d;
    mcand_q <= mcand_d;
    div_q   <= div_d;
    acc_q   <= acc_d;
  end

  // Sequencing and one bit step per cycle
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    mpl_d   = mpl_q;
    mcand_d = mcand_q;
    div_d   = div_q;
    acc_d   = acc_q;
    done_o  = 1'b0;
    unique case (phase_q)
      adsr_pkg::MD_IDLE: begin
        if (start_i) begin
          mpl_d   = mplier_i;
          mcand_d = mcand_i;
          div_d   = divisor_i;
          acc_d   = '0;
          cnt_d   = CNT_LAST;
          phase_d = adsr_pkg::MD_MUL;
        end
      end
      adsr_pkg::MD_MUL: begin
        // multiplier MSB first
        acc_d = {acc_q[W-2:0], 1'b0} + (mpl_q[AMP_BITS-1] ? W'(mcand_q) : W'(0));
        mpl_d = {mpl_q[AMP_BITS-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = CNT_LAST;
          phase_d = adsr_pkg::MD_DIV;
        end
      end
      adsr_pkg::MD_DIV: begin
        // remainder stays below divisor, so the difference fits LEN_BITS
        acc_d = {(ge ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0]),
                 acc_q[AMP_BITS-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          phase_d = adsr_pkg::MD_DONE;
        end
      end
      adsr_pkg::MD_DONE: begin
        done_o  = 1'b1;
        phase_d = adsr_pkg::MD_IDLE;
      end
    endcase
  end

  assign quot_o = acc_q[AMP_BITS-1:0];

  `ADSR_ASSERT(a_md_start_idle, start_i |-> phase_q == adsr_pkg::MD_IDLE, "muldiv started while busy")
  `ADSR_ASSERT(a_md_done_once, done_o |=> phase_q == adsr_pkg::MD_IDLE, "muldiv done not followed by idle")
  `ADSR_ASSERT(a_md_div_after_mul, $rose(phase_q == adsr_pkg::MD_DIV) |-> $past(phase_q == adsr_pkg::MD_MUL), "divide entered without multiply")

endmodule

`default_nettype wire

@@ hw/rtl/adsr_envelope_generator.sv @@
// Top level of the linear ADSR envelope generator with APB register port.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+-------------------------------
//   in      | input     | in_valid_i / in_stall_o | tick_i
//   out     | output    | out_valid_o / out_stall_i | amplitude_o, last_o, status_o
//   cfg     | input     | psel/penable/pwrite     | paddr, pwdata (prdata on reads)
//
// A ramp word goes through segment pick, AMP_BITS shift-add and AMP_BITS divide steps in
// adsr_muldiv, its done state, output load and idle before the next word is accepted.
// Flat and error words skip adsr_muldiv and go from segment pick straight to output load.
// Reset loads the register defaults and clears the sample counter; no clearing pass.
// A stalled result stays in the output register; the next word is taken and worked
// on meanwhile, and waits in the finish state until the output register frees.
`default_nettype none
`include "assert_macros.svh"

module adsr_envelope_generator #(
  parameter int unsigned AMP_BITS = adsr_pkg::AMP_BITS_DEF,
  parameter int unsigned LEN_BITS = adsr_pkg::LEN_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         tick_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [AMP_BITS-1:0]          amplitude_o,
  output logic                         last_o,
  output logic                         status_o,
  // APB register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [adsr_pkg::PADDR_W-1:0] paddr,
  input  logic [adsr_pkg::PDATA_W-1:0] pwdata,
  output logic [adsr_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int unsigned SW = LEN_BITS + 2;

  // Configuration registers
  logic [AMP_BITS-1:0] peak_q, sustain_q;
  logic [LEN_BITS-1:0] att_q, dec_q, rel_q, tot_q;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q    <= '1;
      sustain_q <= {1'b1, {(AMP_BITS-1){1'b0}}};
      att_q     <= '0;
      dec_q     <= '0;
      rel_q     <= '0;
      tot_q     <= LEN_BITS'(1);
    end else if (wr_en) begin
      unique case (paddr[4:2])
        adsr_pkg::REG_PEAK:    peak_q    <= pwdata[AMP_BITS-1:0];
        adsr_pkg::REG_SUSTAIN: sustain_q <= pwdata[AMP_BITS-1:0];
        adsr_pkg::REG_ATTACK:  att_q     <= pwdata[LEN_BITS-1:0];
        adsr_pkg::REG_DECAY:   dec_q     <= pwdata[LEN_BITS-1:0];
        adsr_pkg::REG_RELEASE: rel_q     <= pwdata[LEN_BITS-1:0];
        adsr_pkg::REG_TOTAL:   tot_q     <= pwdata[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[4:2])
      adsr_pkg::REG_PEAK:    prdata = adsr_pkg::PDATA_W'(peak_q);
      adsr_pkg::REG_SUSTAIN: prdata = adsr_pkg::PDATA_W'(sustain_q);
      adsr_pkg::REG_ATTACK:  prdata = adsr_pkg::PDATA_W'(att_q);
      adsr_pkg::REG_DECAY:   prdata = adsr_pkg::PDATA_W'(dec_q);
      adsr_pkg::REG_RELEASE: prdata = adsr_pkg::PDATA_W'(rel_q);
      adsr_pkg::REG_TOTAL:   prdata = adsr_pkg::PDATA_W'(tot_q);
      default:               prdata = '0;
    endcase
  end

  // Sequencer and working registers
  adsr_pkg::state_e    state_q, state_d;
  logic [LEN_BITS-1:0] sample_q, sample_d;
  logic [LEN_BITS-1:0] idx_q, idx_d;
  logic [LEN_BITS-1:0] tlen_q, tlen_d;
  logic [LEN_BITS:0]   ad_q, ad_d;
  logic                last_q, last_d;
  logic [AMP_BITS-1:0] start_q, start_d;
  logic                neg_q, neg_d;
  logic [AMP_BITS-1:0] res_q, res_d;
  logic                err_q, err_d;
  logic                out_valid_q, out_valid_d;
  logic [AMP_BITS-1:0] amp_q, amp_d;
  logic                olast_q, olast_d;
  logic                status_q, status_d;

  // Position of the new sample
  logic [LEN_BITS-1:0] tlen_w, idx_w;
  logic                is_last_w;

  assign tlen_w    = (tot_q == '0) ? LEN_BITS'(1) : tot_q;
  assign idx_w     = (sample_q < tlen_w) ? sample_q : '0;
  assign is_last_w = idx_w == (tlen_w - 1'b1);

  // Segment decode from the latched position
  logic [SW-1:0]       sum_w;
  logic                err_w, in_att_w, in_dec_w, in_rel_w;
  logic [LEN_BITS-1:0] rel_start_w, off_w, len_w;
  logic [AMP_BITS-1:0] seg_start_w, seg_end_w, diff_w;
  logic                flat_w;

  assign sum_w       = SW'(ad_q) + SW'(rel_q);
  assign err_w       = sum_w > SW'(tlen_q);
  assign rel_start_w = tlen_q - rel_q;
  assign in_att_w    = idx_q < att_q;
  assign in_dec_w    = {1'b0, idx_q} < ad_q;
  assign in_rel_w    = idx_q >= rel_start_w;

  always_comb begin
    seg_start_w = sustain_q;
    seg_end_w   = sustain_q;
    off_w       = '0;
    len_w       = rel_q;
    flat_w      = 1'b0;
    if (in_att_w) begin
      seg_start_w = '0;
      seg_end_w   = peak_q;
      off_w       = idx_q;
      len_w       = att_q;
    end else if (in_dec_w) begin
      seg_start_w = peak_q;
      seg_end_w   = sustain_q;
      off_w       = idx_q - att_q;
      len_w       = dec_q;
    end else if (in_rel_w) begin
      seg_start_w = sustain_q;
      seg_end_w   = '0;
      off_w       = idx_q - rel_start_w;
      len_w       = rel_q;
    end else begin
      flat_w = 1'b1;
    end
    diff_w = (seg_end_w >= seg_start_w) ? (seg_end_w - seg_start_w)
                                        : (seg_start_w - seg_end_w);
  end

  // Serial multiply/divide for ramp samples
  logic                md_start, md_done;
  logic [AMP_BITS-1:0] md_quot;

  adsr_muldiv #(
    .AMP_BITS (AMP_BITS),
    .LEN_BITS (LEN_BITS)
  ) u_muldiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (md_start),
    .mplier_i  (diff_w),
    .mcand_i   (off_w),
    .divisor_i (len_w),
    .done_o    (md_done),
    .quot_o    (md_quot)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= adsr_pkg::ST_IDLE;
      sample_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sample_q    <= sample_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    tlen_q   <= tlen_d;
    ad_q     <= ad_d;
    last_q   <= last_d;
    start_q  <= start_d;
    neg_q    <= neg_d;
    res_q    <= res_d;
    err_q    <= err_d;
    amp_q    <= amp_d;
    olast_q  <= olast_d;
    status_q <= status_d;
  end

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    sample_d    = sample_q;
    idx_d       = idx_q;
    tlen_d      = tlen_q;
    ad_d        = ad_q;
    last_d      = last_q;
    start_d     = start_q;
    neg_d       = neg_q;
    res_d       = res_q;
    err_d       = err_q;
    amp_d       = amp_q;
    olast_d     = olast_q;
    status_d    = status_q;
    out_valid_d = out_valid_q & out_stall_i;
    md_start    = 1'b0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      adsr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        // a word with tick low yields nothing
        if (in_valid_i && tick_i) begin
          idx_d    = idx_w;
          tlen_d   = tlen_w;
          ad_d     = {1'b0, att_q} + {1'b0, dec_q};
          last_d   = is_last_w;
          sample_d = is_last_w ? '0 : (idx_w + 1'b1);
          state_d  = adsr_pkg::ST_SEG;
        end
      end
      adsr_pkg::ST_SEG: begin
        err_d   = err_w;
        start_d = seg_start_w;
        neg_d   = seg_end_w < seg_start_w;
        if (err_w || flat_w) begin
          res_d   = err_w ? '0 : sustain_q;
          state_d = adsr_pkg::ST_DONE;
        end else begin
          md_start = 1'b1;
          state_d  = adsr_pkg::ST_CALC;
        end
      end
      adsr_pkg::ST_CALC: begin
        if (md_done) begin
          res_d   = neg_q ? (start_q - md_quot) : (start_q + md_quot);
          state_d = adsr_pkg::ST_DONE;
        end
      end
      adsr_pkg::ST_DONE: begin
        // hand over once the output register is free or being taken
        if (!out_valid_q || !out_stall_i) begin
          amp_d       = res_q;
          olast_d     = last_q;
          status_d    = err_q;
          out_valid_d = 1'b1;
          state_d     = adsr_pkg::ST_IDLE;
        end
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign amplitude_o = amp_q;
  assign last_o      = olast_q;
  assign status_o    = status_q;

  `ADSR_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == adsr_pkg::ST_DONE), "result appeared outside finish state")
  `ADSR_ASSERT(a_err_zero, out_valid_q && status_q |-> amp_q == '0, "error sample with nonzero amplitude")
  `ADSR_ASSERT(a_md_in_calc, md_done |-> state_q == adsr_pkg::ST_CALC, "muldiv finished outside calc state")

endmodule

`default_nettype wire

@@ bench/adsr_envelope_checker.sv @@
`timescale 1ns / 1ps
// Checker: tracks config writes, predicts each envelope sample and compares it on the output.
module adsr_envelope_checker #(
  parameter int unsigned AMP_BITS = adsr_pkg::AMP_BITS_DEF,
  parameter int unsigned LEN_BITS = adsr_pkg::LEN_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_o,
  input  logic                         tick_i,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic [AMP_BITS-1:0]          amplitude_o,
  input  logic                         last_o,
  input  logic                         status_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [adsr_pkg::PADDR_W-1:0] paddr,
  input  logic [adsr_pkg::PDATA_W-1:0] pwdata,
  input  logic                         pready,
  output int                           mismatch_cnt,
  output int                           words_pending
);

  localparam logic [63:0] AMP_MASK = (64'd1 << AMP_BITS) - 64'd1;
  localparam logic [63:0] LEN_MASK = (64'd1 << LEN_BITS) - 64'd1;

  typedef struct packed {
    logic [AMP_BITS-1:0] amp;
    logic                last;
    logic                status;
  } env_sample_t;

  // Expected samples, oldest first
  env_sample_t expected_q[$];

  // Mirror of the register file and the sample counter
  logic [63:0] peak_lvl, hold_lvl, atk_len, dcy_len, rel_len, env_len;
  logic [63:0] sample_pos;
  int          fail_total;

  // Linear interpolation between two levels, quotient truncated toward zero
  function automatic logic [AMP_BITS-1:0] ramp_level(input logic [63:0] from_lvl,
                                                     input logic [63:0] to_lvl,
                                                     input logic [63:0] offs,
                                                     input logic [63:0] seg_len);
    logic [63:0] q;
    if (to_lvl >= from_lvl) begin
      q = ((to_lvl - from_lvl) * offs) / seg_len;
      return AMP_BITS'(from_lvl + q);
    end
    q = ((from_lvl - to_lvl) * offs) / seg_len;
    return AMP_BITS'(from_lvl - q);
  endfunction

  // Next envelope sample; advances the sample counter
  function automatic env_sample_t step_envelope();
    logic [63:0] tlen, idx, dec_end, rel_start;
    env_sample_t s;
    tlen     = (env_len == 64'd0) ? 64'd1 : env_len;
    idx      = (sample_pos < tlen) ? sample_pos : 64'd0;
    s.amp    = '0;
    s.status = 1'b0;
    if (atk_len + dcy_len + rel_len > tlen) begin
      s.status = 1'b1;
    end else begin
      dec_end   = atk_len + dcy_len;
      rel_start = tlen - rel_len;
      if (idx < atk_len) begin
        s.amp = ramp_level(64'd0, peak_lvl, idx, atk_len);
      end else if (idx < dec_end) begin
        s.amp = ramp_level(peak_lvl, hold_lvl, idx - atk_len, dcy_len);
      end else if (idx >= rel_start) begin
        s.amp = ramp_level(hold_lvl, 64'd0, idx - rel_start, rel_len);
      end else begin
        s.amp = AMP_BITS'(hold_lvl);
      end
    end
    s.last     = (idx == tlen - 64'd1);
    sample_pos = s.last ? 64'd0 : ((idx + 64'd1) & LEN_MASK);
    return s;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_total++;
    end
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    env_sample_t want;
    if (!rst_ni) begin
      peak_lvl   = AMP_MASK;
      hold_lvl   = (64'd1 << (AMP_BITS - 1)) & AMP_MASK;
      atk_len    = 64'd0;
      dcy_len    = 64'd0;
      rel_len    = 64'd0;
      env_len    = 64'd1;
      sample_pos = 64'd0;
      fail_total = 0;
      expected_q.delete();
      mismatch_cnt  <= 0;
      words_pending <= 0;
    end else begin
      // register writes, masked to register width
      if (psel && penable && pwrite && pready) begin
        case (paddr[adsr_pkg::PADDR_W-1:2])
          adsr_pkg::REG_PEAK:    peak_lvl = 64'(pwdata) & AMP_MASK;
          adsr_pkg::REG_SUSTAIN: hold_lvl = 64'(pwdata) & AMP_MASK;
          adsr_pkg::REG_ATTACK:  atk_len  = 64'(pwdata) & LEN_MASK;
          adsr_pkg::REG_DECAY:   dcy_len  = 64'(pwdata) & LEN_MASK;
          adsr_pkg::REG_RELEASE: rel_len  = 64'(pwdata) & LEN_MASK;
          adsr_pkg::REG_TOTAL:   env_len  = 64'(pwdata) & LEN_MASK;
          default: ;
        endcase
      end
      // a zero tick produces nothing
      if (in_valid_i && !in_stall_o && tick_i) expected_q.push_back(step_envelope());
      // compare accepted output word against oldest expectation
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual amp %0d last %0d status %0d",
                   $time, amplitude_o, last_o, status_o);
          fail_total++;
        end else begin
          want = expected_q.pop_front();
          check_field("amplitude", 64'(want.amp), 64'(amplitude_o));
          check_field("last", 64'(want.last), 64'(last_o));
          check_field("status", 64'(want.status), 64'(status_o));
        end
      end
      mismatch_cnt  <= fail_total;
      words_pending <= expected_q.size();
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Bench top: clock, reset, register setup, tick stimulus and verdict for the envelope generator.
module tb;

  localparam int unsigned AMP_BITS     = adsr_pkg::AMP_BITS_DEF;
  localparam int unsigned LEN_BITS     = adsr_pkg::LEN_BITS_DEF;
  localparam logic [2:0]  REG_SPARE_LO = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;
  localparam int          TICK_TARGET  = 1300;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          LIMIT_CYCLES = 1000000;
  localparam logic [23:0] LEN_MAX      = 24'hFFFFFF;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         tick_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [AMP_BITS-1:0]          amplitude_o;
  logic                         last_o;
  logic                         status_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [adsr_pkg::PADDR_W-1:0] paddr;
  logic [adsr_pkg::PDATA_W-1:0] pwdata;
  logic [adsr_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  int mismatch_cnt;
  int words_pending;
  int cycle_cnt;
  int ticks_sent;
  bit quiet;

  adsr_envelope_generator #(.AMP_BITS(AMP_BITS), .LEN_BITS(LEN_BITS)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .tick_i(tick_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .amplitude_o(amplitude_o), .last_o(last_o), .status_o(status_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  adsr_envelope_checker #(.AMP_BITS(AMP_BITS), .LEN_BITS(LEN_BITS)) u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .tick_i(tick_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .amplitude_o(amplitude_o), .last_o(last_o), .status_o(status_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatch_cnt(mismatch_cnt), .words_pending(words_pending)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Random backpressure on the output side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 24);
    end
  end

  // APB write: setup and access phases, then back to idle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val,
                           input int unsigned bits);
    logic [31:0] keep;
    keep = (bits >= 32) ? 32'hFFFFFFFF : ((32'd1 << bits) - 32'd1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // junk above the register width must be dropped
    pwdata  <= (val & keep) | ($urandom & ~keep);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_envelope(input logic [15:0] pk, input logic [15:0] hl,
                               input logic [23:0] atk, input logic [23:0] dcy,
                               input logic [23:0] rel, input logic [23:0] len);
    write_reg(adsr_pkg::REG_PEAK, 32'(pk), AMP_BITS);
    write_reg(adsr_pkg::REG_SUSTAIN, 32'(hl), AMP_BITS);
    write_reg(adsr_pkg::REG_ATTACK, 32'(atk), LEN_BITS);
    write_reg(adsr_pkg::REG_DECAY, 32'(dcy), LEN_BITS);
    write_reg(adsr_pkg::REG_RELEASE, 32'(rel), LEN_BITS);
    write_reg(adsr_pkg::REG_TOTAL, 32'(len), LEN_BITS);
    // unmapped addresses must not disturb anything
    if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE_LO, $urandom, 0);
    if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE_HI, $urandom, 0);
  endtask

  // One input word, with random idle cycles ahead of it
  task automatic send_word(input logic t);
    while (!quiet && ($urandom_range(0, 99) < 24)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tick_i     <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (t) ticks_sent++;
  endtask

  // Hold off input until every expected word is out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
  endtask

  // Idle point for register writes: also covers a zero tick still in flight
  task automatic settle();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random envelope shape; mostly short, valid envelopes that wrap often
  task automatic random_envelope();
    logic [23:0] len, atk, dcy, rel;
    int          mode;
    mode = $urandom_range(0, 9);
    if (mode <= 5) begin
      len = 24'($urandom_range(1, 64));
      atk = 24'($urandom_range(0, len));
      dcy = 24'($urandom_range(0, len - atk));
      rel = 24'($urandom_range(0, len - atk - dcy));
    end else if (mode == 6) begin
      // stage lengths overrun the envelope
      len = 24'($urandom_range(0, 40));
      atk = 24'($urandom_range(0, 20));
      dcy = 24'($urandom_range(0, 20));
      rel = 24'($urandom_range(0, 20));
      if (32'(atk) + 32'(dcy) + 32'(rel) <= 32'(len)) rel = len + 24'd1 - atk - dcy;
    end else if (mode == 7) begin
      // long ramps: only the first samples are seen, but the divide is wide
      len = 24'($urandom_range(32'h800000, 32'hFFFFFF));
      atk = 24'($urandom_range(0, len));
      dcy = 24'($urandom_range(0, len - atk));
      rel = 24'($urandom_range(0, len - atk - dcy));
    end else if (mode == 8) begin
      case ($urandom_range(0, 3))
        0: begin len = 24'd0; atk = 24'd0; dcy = 24'd0; rel = 24'd0; end
        1: begin len = 24'd1; atk = 24'd1; dcy = 24'd0; rel = 24'd0; end
        2: begin len = LEN_MAX; atk = LEN_MAX; dcy = LEN_MAX; rel = LEN_MAX; end
        default: begin len = LEN_MAX; atk = 24'd0; dcy = 24'd0; rel = LEN_MAX; end
      endcase
    end else begin
      // short envelope, likely below the running counter
      len = 24'($urandom_range(1, 8));
      atk = 24'($urandom_range(0, len));
      dcy = 24'($urandom_range(0, len - atk));
      rel = 24'($urandom_range(0, len - atk - dcy));
    end
    load_envelope(pick_level(), pick_level(), atk, dcy, rel, len);
  endtask

  initial begin
    int n;
    int phase;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    tick_i     <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    quiet      = 1'b0;
    ticks_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset defaults: flat sustain at half scale, every sample last
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b1);

    // full envelope with falling decay, run past the wrap
    settle();
    load_envelope(16'hFFFF, 16'h4000, 24'd2, 24'd2, 24'd2, 24'd8);
    repeat (9) send_word(1'b1);

    // rising decay from a zero peak
    settle();
    load_envelope(16'h0000, 16'hFFFF, 24'd1, 24'd3, 24'd1, 24'd6);
    repeat (4) send_word(1'b1);

    // stage lengths exceed the total
    settle();
    load_envelope(16'hFFFF, 16'h8000, 24'd3, 24'd3, 24'd3, 24'd8);
    repeat (2) send_word(1'b1);

    // zero total acts as one
    settle();
    load_envelope(16'hFFFF, 16'h1234, 24'd0, 24'd0, 24'd0, 24'd0);
    repeat (2) send_word(1'b1);

    // widest attack ramp
    settle();
    load_envelope(16'hFFFF, 16'h0000, LEN_MAX, 24'd0, 24'd0, LEN_MAX);
    repeat (3) send_word(1'b1);

    // total lowered below the counter: restart at zero
    settle();
    load_envelope(16'hFFFF, 16'h7FFF, 24'd0, 24'd0, 24'd1, 24'd2);
    repeat (2) send_word(1'b1);

    // random phases
    phase = 0;
    while (ticks_sent < TICK_TARGET) begin
      settle();
      random_envelope();
      quiet = (phase >= 6) && (phase < 14);
      n = $urandom_range(10, 60);
      for (int i = 0; i < n; i++) begin
        if ((phase % 5 == 2) && (i == n / 2)) drain_results();
        send_word($urandom_range(0, 9) != 0);
      end
      phase++;
    end
    quiet = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
